// File: hdl/gn2d_pkg.sv
`default_nettype none
package gn2d_pkg;

   localparam int GRID_HALF_DEFAULT = 15;

   localparam int POS_W       = 24;
   localparam int GRAD_W      = 16;
   localparam int INDEX_W     = 10;
   localparam int CELL_SIZE_W = 13;
   localparam int NOISE_W     = 18;
   localparam int FRAC_W      = 16;
   localparam int CELL_W      = POS_W + 1;

   localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RESET = 13'd16;

   localparam logic signed [GRAD_W-1:0] GRAD_ONE = 16'sd16384;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   typedef enum logic {
      FUNC_EVAL = 1'b0,
      FUNC_LOAD = 1'b1
   } func_type;

   typedef struct packed {
      func_type                  func;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic [INDEX_W-1:0]        grad_index;
      logic signed [GRAD_W-1:0]  grad_x;
      logic signed [GRAD_W-1:0]  grad_y;
   } req_word_type;

   typedef struct packed {
      logic signed [NOISE_W-1:0] noise_value;
      logic                      used_default;
   } rsp_word_type;

   typedef struct packed {
      logic                      is_load;
      logic                      load_ok;
      logic [INDEX_W-1:0]        grad_index;
      logic signed [GRAD_W-1:0]  grad_x;
      logic signed [GRAD_W-1:0]  grad_y;
   } load_side_type;

   typedef struct packed {
      load_side_type             side;
      logic                      neg_x;
      logic [POS_W-1:0]          mag_x;
      logic                      neg_y;
      logic [POS_W-1:0]          mag_y;
   } mid_word_type;

   typedef struct packed {
      logic                      valid;
      load_side_type             side;
      logic signed [CELL_W-1:0]  cell_x;
      logic signed [CELL_W-1:0]  cell_y;
      logic [FRAC_W-1:0]         frac_x;
      logic [FRAC_W-1:0]         frac_y;
   } div_word_type;

endpackage
`default_nettype wire

// File: hdl/gn2d_fifo.sv
`default_nettype none
module gn2d_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, wr_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

// File: hdl/gn2d_front.sv
`default_nettype none
module gn2d_front #(
   parameter int GRID_HALF = gn2d_pkg::GRID_HALF_DEFAULT
) (
   input  wire gn2d_pkg::req_word_type req_word,
   output gn2d_pkg::mid_word_type      mid_word
);
   localparam int SPAN  = 2 * GRID_HALF + 1;
   localparam int DEPTH = SPAN * SPAN;

   // sign/magnitude split so the divider works on unsigned words
   always_comb begin
      mid_word.side.is_load    = (req_word.func == gn2d_pkg::FUNC_LOAD);
      mid_word.side.load_ok    = (int'(req_word.grad_index) < DEPTH);
      mid_word.side.grad_index = req_word.grad_index;
      mid_word.side.grad_x     = req_word.grad_x;
      mid_word.side.grad_y     = req_word.grad_y;
      mid_word.neg_x           = req_word.pos_x[gn2d_pkg::POS_W-1];
      mid_word.neg_y           = req_word.pos_y[gn2d_pkg::POS_W-1];
      mid_word.mag_x           = mid_word.neg_x ? gn2d_pkg::POS_W'(-req_word.pos_x)
                                                : gn2d_pkg::POS_W'(req_word.pos_x);
      mid_word.mag_y           = mid_word.neg_y ? gn2d_pkg::POS_W'(-req_word.pos_y)
                                                : gn2d_pkg::POS_W'(req_word.pos_y);
   end
endmodule
`default_nettype wire

// File: hdl/gn2d_divide.sv
`default_nettype none
module gn2d_divide (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic [gn2d_pkg::CELL_SIZE_W-1:0]    cell_size,
   input  wire logic                                in_valid,
   input  wire gn2d_pkg::mid_word_type              in_word,
   output gn2d_pkg::div_word_type                   out_word
);
   localparam int RW      = gn2d_pkg::CELL_SIZE_W;
   localparam int MAG_W   = gn2d_pkg::POS_W;
   localparam int FW      = gn2d_pkg::FRAC_W;
   localparam int CW      = gn2d_pkg::CELL_W;
   localparam int INT_ST  = MAG_W;
   localparam int FRAC_ST = FW;
   localparam int TOT_ST  = INT_ST + 1 + FRAC_ST;

   // one restoring step: {new remainder, quotient bit}
   function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic b,
                                            input logic [RW-1:0] d);
      logic [RW:0] t;
      logic        ge;
      logic [RW:0] r;
      t  = {rem, b};
      ge = (t >= {1'b0, d});
      r  = ge ? t - {1'b0, d} : t;
      return {r[RW-1:0], ge};
   endfunction

   logic [RW-1:0] cs;
   assign cs = (cell_size == '0) ? RW'(1) : cell_size;

   logic                    valid_ff [TOT_ST];
   gn2d_pkg::load_side_type side_ff  [TOT_ST];

   logic [MAG_W-1:0] mag_in [2];
   logic             neg_in [2];
   assign mag_in[0] = in_word.mag_x;
   assign mag_in[1] = in_word.mag_y;
   assign neg_in[0] = in_word.neg_x;
   assign neg_in[1] = in_word.neg_y;

   logic [RW-1:0]        irem_ff  [2][INT_ST];
   logic [MAG_W-1:0]     idq_ff   [2][INT_ST];
   logic                 ineg_ff  [2][INT_ST];
   logic signed [CW-1:0] ccell_ff [2];
   logic [RW-1:0]        crem_ff  [2];
   logic [RW-1:0]        frem_ff  [2][FRAC_ST];
   logic [FW-1:0]        fq_ff    [2][FRAC_ST];
   logic signed [CW-1:0] fcell_ff [2][FRAC_ST];

   // sideband delay line
   for (genvar s = 0; s < TOT_ST; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= (s == 0) ? in_word.side : side_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      // integer quotient, one bit per stage
      for (genvar s = 0; s < INT_ST; s++) begin : g_int
         logic [RW-1:0]    rem_src;
         logic [MAG_W-1:0] dq_src;
         logic             neg_src;
         logic [RW:0]      st;
         if (s == 0) begin : g_first
            assign rem_src = '0;
            assign dq_src  = mag_in[l];
            assign neg_src = neg_in[l];
         end else begin : g_next
            assign rem_src = irem_ff[l][s-1];
            assign dq_src  = idq_ff[l][s-1];
            assign neg_src = ineg_ff[l][s-1];
         end
         assign st = div_step(rem_src, dq_src[MAG_W-1], cs);
         always_ff @(posedge clock) begin
            if (en) begin
               irem_ff[l][s] <= st[RW:1];
               idq_ff[l][s]  <= {dq_src[MAG_W-2:0], st[0]};
               ineg_ff[l][s] <= neg_src;
            end
         end
      end

      // floor correction for negative positions
      logic [MAG_W-1:0]     q_last;
      logic [RW-1:0]        r_last;
      logic signed [CW-1:0] q_s;
      logic signed [CW-1:0] ccell_in;
      logic [RW-1:0]        crem_in;
      assign q_last = idq_ff[l][INT_ST-1];
      assign r_last = irem_ff[l][INT_ST-1];
      assign q_s    = $signed({1'b0, q_last});
      always_comb begin
         ccell_in = q_s;
         crem_in  = r_last;
         if (ineg_ff[l][INT_ST-1]) begin
            if (r_last != '0) begin
               ccell_in = -(q_s + CW'(1));
               crem_in  = cs - r_last;
            end else begin
               ccell_in = -q_s;
               crem_in  = '0;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ccell_ff[l] <= ccell_in;
            crem_ff[l]  <= crem_in;
         end
      end

      // fraction bits of rem / cs
      for (genvar s = 0; s < FRAC_ST; s++) begin : g_frac
         logic [RW-1:0]        rem_src;
         logic [FW-1:0]        fq_src;
         logic signed [CW-1:0] cell_src;
         logic [RW:0]          st;
         if (s == 0) begin : g_first
            assign rem_src  = crem_ff[l];
            assign fq_src   = '0;
            assign cell_src = ccell_ff[l];
         end else begin : g_next
            assign rem_src  = frem_ff[l][s-1];
            assign fq_src   = fq_ff[l][s-1];
            assign cell_src = fcell_ff[l][s-1];
         end
         assign st = div_step(rem_src, 1'b0, cs);
         always_ff @(posedge clock) begin
            if (en) begin
               frem_ff[l][s]  <= st[RW:1];
               fq_ff[l][s]    <= {fq_src[FW-2:0], st[0]};
               fcell_ff[l][s] <= cell_src;
            end
         end
      end
   end

   always_comb begin
      out_word.valid  = valid_ff[TOT_ST-1];
      out_word.side   = side_ff[TOT_ST-1];
      out_word.cell_x = fcell_ff[0][FRAC_ST-1];
      out_word.cell_y = fcell_ff[1][FRAC_ST-1];
      out_word.frac_x = fq_ff[0][FRAC_ST-1];
      out_word.frac_y = fq_ff[1][FRAC_ST-1];
   end
endmodule
`default_nettype wire

// File: hdl/gn2d_eval.sv
`default_nettype none
module gn2d_eval #(
   parameter int GRID_HALF = gn2d_pkg::GRID_HALF_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire gn2d_pkg::div_word_type d_in,
   output logic                        o_valid,
   output gn2d_pkg::rsp_word_type      o_word
);
   localparam int SPAN   = 2 * GRID_HALF + 1;
   localparam int DEPTH  = SPAN * SPAN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(SPAN);
   localparam int CW     = gn2d_pkg::CELL_W;
   localparam int CW1    = CW + 1;
   localparam int FW     = gn2d_pkg::FRAC_W;
   localparam int GW     = gn2d_pkg::GRAD_W;
   localparam int NW     = gn2d_pkg::NOISE_W;
   localparam logic signed [CW1-1:0] G_POS = CW1'(GRID_HALF);
   localparam logic signed [CW1-1:0] G_NEG = -G_POS;
   localparam logic signed [24:0] SAT_MAX = 25'sd131071;
   localparam logic signed [24:0] SAT_MIN = -25'sd131072;

   // two copies, each with two read ports: low-x corners and high-x corners
   logic [2*GW-1:0] mem_a [DEPTH];
   logic [2*GW-1:0] mem_b [DEPTH];

   // E0: corner addresses and range flags
   logic signed [CW1-1:0] cx0, cx1, cy0, cy1;
   logic [IDX_W-1:0]      ix0, ix1, iy0, iy1;
   logic [ADDR_W-1:0]     addr [4];
   logic                  inr_in [4];
   logic                  we;
   logic [ADDR_W-1:0]     waddr;

   assign cx0 = CW1'(d_in.cell_x);
   assign cy0 = CW1'(d_in.cell_y);
   assign cx1 = cx0 + CW1'(1);
   assign cy1 = cy0 + CW1'(1);
   assign ix0 = IDX_W'(cx0 + G_POS);
   assign ix1 = IDX_W'(cx1 + G_POS);
   assign iy0 = IDX_W'(cy0 + G_POS);
   assign iy1 = IDX_W'(cy1 + G_POS);

   // corner order: {x high, y high}
   assign addr[0] = ADDR_W'(ix0) * ADDR_W'(SPAN) + ADDR_W'(iy0);
   assign addr[1] = ADDR_W'(ix0) * ADDR_W'(SPAN) + ADDR_W'(iy1);
   assign addr[2] = ADDR_W'(ix1) * ADDR_W'(SPAN) + ADDR_W'(iy0);
   assign addr[3] = ADDR_W'(ix1) * ADDR_W'(SPAN) + ADDR_W'(iy1);

   assign inr_in[0] = (cx0 >= G_NEG) && (cx0 <= G_POS) && (cy0 >= G_NEG) && (cy0 <= G_POS);
   assign inr_in[1] = (cx0 >= G_NEG) && (cx0 <= G_POS) && (cy1 >= G_NEG) && (cy1 <= G_POS);
   assign inr_in[2] = (cx1 >= G_NEG) && (cx1 <= G_POS) && (cy0 >= G_NEG) && (cy0 <= G_POS);
   assign inr_in[3] = (cx1 >= G_NEG) && (cx1 <= G_POS) && (cy1 >= G_NEG) && (cy1 <= G_POS);

   assign we    = en && d_in.valid && d_in.side.is_load && d_in.side.load_ok;
   assign waddr = ADDR_W'(d_in.side.grad_index);

   logic [2*GW-1:0] rd1_ff [4];
   logic            inr1_ff [4];
   logic            v1_ff;
   logic [FW-1:0]   fx1_ff, fy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_a[waddr] <= {d_in.side.grad_y, d_in.side.grad_x};
            mem_b[waddr] <= {d_in.side.grad_y, d_in.side.grad_x};
         end
         rd1_ff[0] <= mem_a[addr[0]];
         rd1_ff[1] <= mem_a[addr[1]];
         rd1_ff[2] <= mem_b[addr[2]];
         rd1_ff[3] <= mem_b[addr[3]];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            inr1_ff[c] <= inr_in[c];
         end
         fx1_ff <= d_in.frac_x;
         fy1_ff <= d_in.frac_y;
      end
   end

   // E1: pick gradient or default, multiply
   logic signed [17:0] dxl, dxh, dyl, dyh;
   logic signed [33:0] pgx_ff [4];
   logic signed [33:0] pgy_ff [4];
   logic               v2_ff, df2_ff;
   logic [FW-1:0]      fx2_ff, fy2_ff;

   assign dxl = $signed({2'b00, fx1_ff});
   assign dyl = $signed({2'b00, fy1_ff});
   assign dxh = dxl - 18'sd65536;
   assign dyh = dyl - 18'sd65536;

   for (genvar c = 0; c < 4; c++) begin : g_dot
      logic signed [GW-1:0] gx, gy;
      logic signed [17:0]   dx, dy;
      assign gx = inr1_ff[c] ? $signed(rd1_ff[c][GW-1:0]) : gn2d_pkg::GRAD_ONE;
      assign gy = inr1_ff[c] ? $signed(rd1_ff[c][2*GW-1:GW]) : '0;
      assign dx = c[1] ? dxh : dxl;
      assign dy = c[0] ? dyh : dyl;
      always_ff @(posedge clock) begin
         if (en) begin
            pgx_ff[c] <= gx * dx;
            pgy_ff[c] <= gy * dy;
         end
      end
   end

   // E2: sum and floor to Q.16
   logic signed [20:0] d3_ff [4];
   logic               v3_ff, df3_ff;
   logic [FW-1:0]      fx3_ff, fy3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            d3_ff[c] <= 21'((35'(pgx_ff[c]) + 35'(pgy_ff[c])) >>> 14);
         end
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
      end
   end

   // E3: blend along y, multiply
   logic signed [21:0] dif0, dif1;
   logic signed [16:0] fy_s;
   logic signed [38:0] py0_ff, py1_ff;
   logic signed [20:0] a0_ff, a1_ff;
   logic               v4_ff, df4_ff;
   logic [FW-1:0]      fx4_ff;

   assign dif0 = 22'(d3_ff[1]) - 22'(d3_ff[0]);
   assign dif1 = 22'(d3_ff[3]) - 22'(d3_ff[2]);
   assign fy_s = $signed({1'b0, fy3_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         py0_ff <= dif0 * fy_s;
         py1_ff <= dif1 * fy_s;
         a0_ff  <= d3_ff[0];
         a1_ff  <= d3_ff[2];
         fx4_ff <= fx3_ff;
      end
   end

   // E4: finish y blend
   logic signed [22:0] l0_ff, l1_ff;
   logic               v5_ff, df5_ff;
   logic [FW-1:0]      fx5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         l0_ff  <= 23'(a0_ff) + $signed(py0_ff[38:16]);
         l1_ff  <= 23'(a1_ff) + $signed(py1_ff[38:16]);
         fx5_ff <= fx4_ff;
      end
   end

   // E5: blend along x, multiply
   logic signed [23:0] difx;
   logic signed [16:0] fx_s;
   logic signed [40:0] px_ff;
   logic signed [22:0] l0b_ff;
   logic               v6_ff, df6_ff;

   assign difx = 24'(l1_ff) - 24'(l0_ff);
   assign fx_s = $signed({1'b0, fx5_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= difx * fx_s;
         l0b_ff <= l0_ff;
      end
   end

   // control: query valids and default flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= d_in.valid && !d_in.side.is_load;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         df2_ff <= !(inr1_ff[0] && inr1_ff[1] && inr1_ff[2] && inr1_ff[3]);
         df3_ff <= df2_ff;
         df4_ff <= df3_ff;
         df5_ff <= df4_ff;
         df6_ff <= df5_ff;
      end
   end

   // E6: final add and saturate
   logic signed [24:0] v_sum;
   assign v_sum = 25'(l0b_ff) + $signed(px_ff[40:16]);

   always_comb begin
      o_valid             = v6_ff;
      o_word.used_default = df6_ff;
      if (v_sum > SAT_MAX) begin
         o_word.noise_value = NW'(SAT_MAX);
      end else if (v_sum < SAT_MIN) begin
         o_word.noise_value = NW'(SAT_MIN);
      end else begin
         o_word.noise_value = NW'(v_sum);
      end
   end

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (en && d_in.valid && d_in.side.is_load) |=> !v1_ff)
      else $error("load word entered the result path");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(v6_ff) && $stable(v1_ff)))
      else $error("pipeline moved while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!o_valid && !v1_ff))
      else $error("result valid after reset");
endmodule
`default_nettype wire

// File: hdl/gradient_noise_2d_core.sv
// Gradient noise core: 2D lattice gradient noise with a loadable gradient table.
// Words pass the request queue, 41 divider stages, 6 evaluation stages and the result
// queue; the divider and evaluation pipeline advance together.
// Throughput: one word per cycle while the result queue has a free slot.
// Reset: synchronous, active high; clears queues, valids, cell_size to 16.
// The gradient table is not cleared by reset: entries read before written are undefined.
`default_nettype none
module gradient_noise_2d_core #(
   parameter int GRID_HALF = gn2d_pkg::GRID_HALF_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request queue side
   input  wire logic                             push,
   output logic                                  full,
   input  wire gn2d_pkg::req_word_type           req_word,
   // result queue side
   output logic                                  empty,
   input  wire logic                             pop,
   output gn2d_pkg::rsp_word_type                rsp_word,
   // cell_size register
   input  wire logic                             csr_write_enable,
   input  wire logic [gn2d_pkg::CELL_SIZE_W-1:0] csr_write_data
);
   localparam int MID_W = $bits(gn2d_pkg::mid_word_type);
   localparam int RSP_W = $bits(gn2d_pkg::rsp_word_type);

   // cell size register; zero is treated as one in the divider
   logic [gn2d_pkg::CELL_SIZE_W-1:0] cell_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= gn2d_pkg::CELL_SIZE_RESET;
      end else if (csr_write_enable) begin
         cell_size_ff <= csr_write_data;
      end
   end

   // front: sign/magnitude split and load-index check, straight into the queue
   gn2d_pkg::mid_word_type mid_in_word, mid_out_word;
   logic [MID_W-1:0]       mid_in_bits, mid_out_bits;
   logic                   mid_empty;

   gn2d_front #(.GRID_HALF(GRID_HALF)) u_front (
      .req_word (req_word),
      .mid_word (mid_in_word)
   );

   assign mid_in_bits  = mid_in_word;
   assign mid_out_word = mid_out_bits;

   // back pipeline moves only while the result queue has a free slot;
   // every stage holds on stall, so the result queue never overflows
   logic en;
   logic out_full;
   assign en = !out_full;

   gn2d_fifo #(.WIDTH(MID_W), .DEPTH(gn2d_pkg::MID_DEPTH)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (mid_in_bits),
      .full      (full),
      .pop       (en),
      .pop_data  (mid_out_bits),
      .empty     (mid_empty)
   );

   // back, part one: floored division of both axes by cell_size
   gn2d_pkg::div_word_type div_word;

   gn2d_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cell_size (cell_size_ff),
      .in_valid  (!mid_empty),
      .in_word   (mid_out_word),
      .out_word  (div_word)
   );

   // back, part two: table access (loads write here), dots, blends
   logic                   res_valid;
   gn2d_pkg::rsp_word_type res_word;
   logic [RSP_W-1:0]       res_bits, rsp_bits;

   gn2d_eval #(.GRID_HALF(GRID_HALF)) u_eval (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .d_in    (div_word),
      .o_valid (res_valid),
      .o_word  (res_word)
   );

   assign res_bits = res_word;

   // result queue: output register stage between pipeline and consumer
   gn2d_fifo #(.WIDTH(RSP_W), .DEPTH(gn2d_pkg::OUT_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (en && res_valid),
      .push_data (res_bits),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_word = rsp_bits;
endmodule
`default_nettype wire
